@@ design/rpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types, constants and a saturating adder for the random projection
// embedding unit.
// ----------------------------------------------------------------------------
package rpe_pkg;

   localparam int NODE_W    = 10;
   localparam int DIM_W     = 3;
   localparam int ADDR_W    = NODE_W + DIM_W;
   localparam int EDGE_AW   = 12;
   localparam int VAL_W     = 48;
   localparam int COEF_W    = 32;
   localparam int NUM_COEF  = 5;
   localparam int MAX_NODES = 1024;
   localparam int MAX_DIMS  = 8;
   localparam int MAX_ORDER = 4;
   localparam int MAX_EDGES = 4096;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_EDGE  = 3'd1,
      OP_RUN   = 3'd2,
      OP_READ  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_NODE_COUNT = 3'd0,
      REG_DIM_COUNT  = 3'd1,
      REG_ORDER      = 3'd2,
      REG_COEF_0     = 3'd3,
      REG_COEF_1     = 3'd4,
      REG_COEF_2     = 3'd5,
      REG_COEF_3     = 3'd6,
      REG_COEF_4     = 3'd7
   } reg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_CLR,
      ST_AS_RD,
      ST_AS_W1,
      ST_AS_W2,
      ST_AS_WR,
      ST_ZERO,
      ST_ED_RD,
      ST_ED_W,
      ST_CT_W,
      ST_CS_W,
      ST_NS_W,
      ST_NT_RD,
      ST_NT_W,
      ST_CP_RD,
      ST_CP_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    sat;
      logic signed [VAL_W-1:0] value;
   } sat_result_type;

   function automatic sat_result_type sat_add48(input logic signed [VAL_W-1:0] a,
                                                input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] sum;
      sat_result_type        res;
      sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (sum[VAL_W] != sum[VAL_W-1]) begin
         res.sat   = 1'b1;
         res.value = sum[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         res.sat   = 1'b0;
         res.value = sum[VAL_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ design/graph_random_projection_embedding_unit.sv @@
// ----------------------------------------------------------------------------
// graph_random_projection_embedding_unit
// Iterative random-projection graph embedding over stored edges.
// ----------------------------------------------------------------------------
// Load, add-edge, clear-edges and unknown ops answer straight from idle; an
// in-range read waits in ST_RD_WAIT for the registered embedding RAM data.
// A run first sweeps all 8192 embedding words to zero, then for each positive
// coefficient passes every word in use through read, two multiply stages and
// write back, and per order and dimension does zeroing, edge scatter and
// copy-back. The scatter runs one edge at a time through single-port-read
// RAMs, so run time is set by the edge walk and the read-modify-write on the
// next-vector RAM.
module graph_random_projection_embedding_unit
   import rpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // node[9:0], dim[12:10], proj_value[44:13], edge_source[54:45],
   // edge_target[64:55], zeros above
   input  logic [71:0] req_tdata,
   // op[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value[47:0], status[49:48], saturated[50], zeros above
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [NODE_W-1:0] req_node, req_src, req_dst;
   logic [DIM_W-1:0]  req_dim;
   logic [31:0]       req_pv;
   op_type            req_op;
   logic              req_accept;

   assign req_node   = req_tdata[9:0];
   assign req_dim    = req_tdata[12:10];
   assign req_pv     = req_tdata[44:13];
   assign req_src    = req_tdata[54:45];
   assign req_dst    = req_tdata[64:55];
   assign req_op     = op_type'(req_tuser);
   assign req_accept = req_tvalid && req_tready;

   // configuration registers
   logic [10:0]               node_count_ff;
   logic [3:0]                dim_count_ff;
   logic [2:0]                order_ff;
   logic signed [COEF_W-1:0]  coef_ff [NUM_COEF];
   logic                      csr_write;
   reg_type                   csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 11'(MAX_NODES);
         dim_count_ff  <= 4'(MAX_DIMS);
         order_ff      <= 3'd1;
         coef_ff[0]    <= 32'sd16777216;
         coef_ff[1]    <= 32'sd16777216;
         coef_ff[2]    <= '0;
         coef_ff[3]    <= '0;
         coef_ff[4]    <= '0;
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_NODE_COUNT: node_count_ff <= (csr_pwdata[10:0] > 11'(MAX_NODES)) ?
                                             11'(MAX_NODES) : csr_pwdata[10:0];
            REG_DIM_COUNT:  dim_count_ff  <= (csr_pwdata[3:0] > 4'(MAX_DIMS)) ?
                                             4'(MAX_DIMS) : csr_pwdata[3:0];
            REG_ORDER:      order_ff      <= (csr_pwdata[2:0] > 3'(MAX_ORDER)) ?
                                             3'(MAX_ORDER) : csr_pwdata[2:0];
            REG_COEF_0:     coef_ff[0]    <= csr_pwdata;
            REG_COEF_1:     coef_ff[1]    <= csr_pwdata;
            REG_COEF_2:     coef_ff[2]    <= csr_pwdata;
            REG_COEF_3:     coef_ff[3]    <= csr_pwdata;
            REG_COEF_4:     coef_ff[4]    <= csr_pwdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_NODE_COUNT: csr_prdata = 32'(node_count_ff);
         REG_DIM_COUNT:  csr_prdata = 32'(dim_count_ff);
         REG_ORDER:      csr_prdata = 32'(order_ff);
         REG_COEF_0:     csr_prdata = coef_ff[0];
         REG_COEF_1:     csr_prdata = coef_ff[1];
         REG_COEF_2:     csr_prdata = coef_ff[2];
         REG_COEF_3:     csr_prdata = coef_ff[3];
         REG_COEF_4:     csr_prdata = coef_ff[4];
         default:        csr_prdata = '0;
      endcase
   end

   // memories
   logic                cur_we, nxt_we, emb_we, edg_we;
   logic [ADDR_W-1:0]   cur_waddr, cur_raddr, nxt_waddr, nxt_raddr;
   logic [ADDR_W-1:0]   emb_waddr, emb_raddr;
   logic [EDGE_AW-1:0]  edg_waddr, edg_raddr;
   logic [VAL_W-1:0]    cur_wdata, cur_rdata, nxt_wdata, nxt_rdata;
   logic [VAL_W-1:0]    emb_wdata, emb_rdata;
   logic [2*NODE_W-1:0] edg_wdata, edg_rdata;

   rpe_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_cur (
      .clock(clock), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
      .raddr(cur_raddr), .rdata(cur_rdata));

   rpe_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_nxt (
      .clock(clock), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
      .raddr(nxt_raddr), .rdata(nxt_rdata));

   rpe_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_emb (
      .clock(clock), .we(emb_we), .waddr(emb_waddr), .wdata(emb_wdata),
      .raddr(emb_raddr), .rdata(emb_rdata));

   rpe_ram #(.ADDR_W(EDGE_AW), .DATA_W(2*NODE_W)) u_edg (
      .clock(clock), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
      .raddr(edg_raddr), .rdata(edg_rdata));

   // sequencer state
   state_type           state_ff, state_in;
   logic [NODE_W-1:0]   n_ff, n_in, src_ff, src_in, dst_ff, dst_in;
   logic [DIM_W-1:0]    j_ff, j_in;
   logic [EDGE_AW-1:0]  e_ff, e_in;
   logic [2:0]          k_ff, k_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [12:0]         edge_total_ff, edge_total_in;
   logic signed [VAL_W-1:0] cur_t_ff, cur_t_in, cur_s_ff, cur_s_in;
   logic signed [VAL_W-1:0] emb_hold_ff, emb_hold_in;
   logic                sat_ff, sat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_sat_ff, rsp_sat_in;

   logic                rsp_load;
   logic [VAL_W-1:0]    rsp_value_sel;
   status_type          rsp_status_sel;
   logic                req_in_range, edge_in_range, stored_in_range;
   logic                n_last, j_last, e_last;
   logic [NODE_W-1:0]   e_src, e_dst;
   sat_result_type      acc;

   // coefficient scaler runs free on the current-vector read data
   logic signed [COEF_W-1:0] coef_sel;
   logic                     add_go;
   logic signed [VAL_W-1:0]  scaled;
   logic                     scale_sat;

   assign coef_sel = coef_ff[k_ff];
   assign add_go   = coef_sel > 0;

   rpe_scale u_scale (
      .clock(clock), .coef(coef_sel[COEF_W-2:0]), .value(cur_rdata),
      .scaled(scaled), .sat(scale_sat));

   assign e_src           = edg_rdata[NODE_W-1:0];
   assign e_dst           = edg_rdata[2*NODE_W-1:NODE_W];
   assign req_in_range    = ({1'b0, req_node} < node_count_ff) &&
                            ({1'b0, req_dim} < dim_count_ff);
   assign edge_in_range   = ({1'b0, req_src} < node_count_ff) &&
                            ({1'b0, req_dst} < node_count_ff);
   assign stored_in_range = ({1'b0, e_src} < node_count_ff) &&
                            ({1'b0, e_dst} < node_count_ff);
   assign n_last = ({1'b0, n_ff} == node_count_ff - 11'd1);
   assign j_last = ({1'b0, j_ff} == dim_count_ff - 4'd1);
   assign e_last = ({1'b0, e_ff} == edge_total_ff - 13'd1);

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      e_in          = e_ff;
      k_in          = k_ff;
      clr_in        = clr_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      cur_t_in      = cur_t_ff;
      cur_s_in      = cur_s_ff;
      emb_hold_in   = emb_hold_ff;
      sat_in        = sat_ff;
      edge_total_in = edge_total_ff;

      rsp_load       = 1'b0;
      rsp_value_sel  = '0;
      rsp_status_sel = STATUS_OK;
      acc            = '0;

      cur_we    = 1'b0;
      cur_waddr = {n_ff, j_ff};
      cur_wdata = nxt_rdata;
      cur_raddr = {n_ff, j_ff};
      nxt_we    = 1'b0;
      nxt_waddr = {n_ff, j_ff};
      nxt_wdata = '0;
      nxt_raddr = {n_ff, j_ff};
      emb_we    = 1'b0;
      emb_waddr = {n_ff, j_ff};
      emb_wdata = '0;
      emb_raddr = {n_ff, j_ff};
      edg_we    = 1'b0;
      edg_waddr = edge_total_ff[EDGE_AW-1:0];
      edg_wdata = {req_dst, req_src};
      edg_raddr = e_ff;

      unique case (state_ff)
         ST_IDLE: begin
            emb_raddr = {req_node, req_dim};
            if (req_accept) begin
               unique case (req_op)
                  OP_LOAD: begin
                     rsp_load = 1'b1;
                     if (req_in_range) begin
                        cur_we    = 1'b1;
                        cur_waddr = {req_node, req_dim};
                        cur_wdata = {{(VAL_W-32){req_pv[31]}}, req_pv};
                     end else begin
                        rsp_status_sel = STATUS_RANGE;
                     end
                  end
                  OP_EDGE: begin
                     rsp_load = 1'b1;
                     if (!edge_in_range) begin
                        rsp_status_sel = STATUS_RANGE;
                     end else if (edge_total_ff == 13'(MAX_EDGES)) begin
                        rsp_status_sel = STATUS_FULL;
                     end else begin
                        edg_we        = 1'b1;
                        edge_total_in = edge_total_ff + 13'd1;
                     end
                  end
                  OP_RUN: begin
                     sat_in   = 1'b0;
                     clr_in   = '0;
                     k_in     = '0;
                     state_in = ST_CLR;
                  end
                  OP_READ: begin
                     if (req_in_range) begin
                        state_in = ST_RD_WAIT;
                     end else begin
                        rsp_load       = 1'b1;
                        rsp_status_sel = STATUS_RANGE;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_load      = 1'b1;
                     edge_total_in = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_load      = 1'b1;
            rsp_value_sel = emb_rdata;
            state_in      = ST_IDLE;
         end
         ST_CLR: begin
            emb_we    = 1'b1;
            emb_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               n_in = '0;
               j_in = '0;
               // no node or no dimension in use: nothing beyond the clear
               if (node_count_ff == '0 || dim_count_ff == '0) begin
                  state_in = ST_DONE;
               end else if (add_go) begin
                  state_in = ST_AS_RD;
               end else if (k_ff == order_ff) begin
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = ST_ZERO;
               end
            end
         end
         ST_AS_RD: begin
            state_in = ST_AS_W1;
         end
         ST_AS_W1: begin
            emb_hold_in = emb_rdata;
            state_in    = ST_AS_W2;
         end
         ST_AS_W2: begin
            state_in = ST_AS_WR;
         end
         ST_AS_WR: begin
            acc       = sat_add48(emb_hold_ff, scaled);
            emb_we    = 1'b1;
            emb_wdata = acc.value;
            sat_in    = sat_ff | scale_sat | acc.sat;
            state_in  = ST_AS_RD;
            if (j_last) begin
               j_in = '0;
               if (n_last) begin
                  n_in = '0;
                  if (k_ff == order_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     k_in     = k_ff + 3'd1;
                     state_in = ST_ZERO;
                  end
               end else begin
                  n_in = n_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_ZERO: begin
            nxt_we = 1'b1;
            if (n_last) begin
               n_in     = '0;
               e_in     = '0;
               state_in = (edge_total_ff == '0) ? ST_CP_RD : ST_ED_RD;
            end else begin
               n_in = n_ff + 1'b1;
            end
         end
         ST_ED_RD: begin
            state_in = ST_ED_W;
         end
         ST_ED_W: begin
            src_in    = e_src;
            dst_in    = e_dst;
            cur_raddr = {e_dst, j_ff};
            if (stored_in_range) begin
               state_in = ST_CT_W;
            end else if (e_last) begin
               n_in     = '0;
               state_in = ST_CP_RD;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = ST_ED_RD;
            end
         end
         ST_CT_W: begin
            cur_t_in  = cur_rdata;
            cur_raddr = {src_ff, j_ff};
            state_in  = ST_CS_W;
         end
         ST_CS_W: begin
            cur_s_in  = cur_rdata;
            nxt_raddr = {src_ff, j_ff};
            state_in  = ST_NS_W;
         end
         ST_NS_W: begin
            acc       = sat_add48(nxt_rdata, cur_t_ff);
            nxt_we    = 1'b1;
            nxt_waddr = {src_ff, j_ff};
            nxt_wdata = acc.value;
            sat_in    = sat_ff | acc.sat;
            state_in  = ST_NT_RD;
         end
         ST_NT_RD: begin
            // the source write has landed, so a self-loop sees it here
            nxt_raddr = {dst_ff, j_ff};
            state_in  = ST_NT_W;
         end
         ST_NT_W: begin
            acc       = sat_add48(nxt_rdata, cur_s_ff);
            nxt_we    = 1'b1;
            nxt_waddr = {dst_ff, j_ff};
            nxt_wdata = acc.value;
            sat_in    = sat_ff | acc.sat;
            if (e_last) begin
               n_in     = '0;
               state_in = ST_CP_RD;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = ST_ED_RD;
            end
         end
         ST_CP_RD: begin
            state_in = ST_CP_WR;
         end
         ST_CP_WR: begin
            cur_we   = 1'b1;
            state_in = ST_CP_RD;
            if (n_last) begin
               n_in = '0;
               if (j_last) begin
                  j_in = '0;
                  if (add_go) begin
                     state_in = ST_AS_RD;
                  end else if (k_ff == order_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     k_in     = k_ff + 3'd1;
                     state_in = ST_ZERO;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_ZERO;
               end
            end else begin
               n_in = n_ff + 1'b1;
            end
         end
         ST_DONE: begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register: load a finished transaction, else drain
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rsp_value_sel;
         rsp_status_in = rsp_status_sel;
         rsp_sat_in    = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_total_ff <= '0;
         sat_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         n_ff          <= '0;
         j_ff          <= '0;
         e_ff          <= '0;
         k_ff          <= '0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         sat_ff        <= sat_in;
         rsp_valid_ff  <= rsp_valid_in;
         n_ff          <= n_in;
         j_ff          <= j_in;
         e_ff          <= e_in;
         k_ff          <= k_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      cur_t_ff      <= cur_t_in;
      cur_s_ff      <= cur_s_in;
      emb_hold_ff   <= emb_hold_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_sat_ff, rsp_status_ff, rsp_value_ff};

endmodule

@@ design/rpe_ram.sv @@
// ----------------------------------------------------------------------------
// rpe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpe_ram #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/rpe_scale.sv @@
// ----------------------------------------------------------------------------
// rpe_scale
// Two-stage coefficient multiply: round(coef * value / 2^24), saturated to
// 48 bits. The value is split into a signed high and an unsigned low part.
// ----------------------------------------------------------------------------
module rpe_scale
   import rpe_pkg::*;
(
   input  logic                    clock,
   input  logic [COEF_W-2:0]       coef,
   input  logic signed [VAL_W-1:0] value,
   output logic signed [VAL_W-1:0] scaled,
   output logic                    sat
);

   logic signed [55:0]      p_hi_ff, p_hi_in;
   logic [54:0]             p_lo_ff, p_lo_in;
   logic signed [VAL_W-1:0] scaled_ff, scaled_in;
   logic                    sat_ff, sat_in;
   logic [31:0]             low_part;
   logic signed [56:0]      sum;

   always_comb begin
      p_hi_in  = $signed({1'b0, coef}) * $signed(value[VAL_W-1:24]);
      p_lo_in  = 55'(coef) * 55'(value[23:0]);
      low_part = 32'((p_lo_ff + 55'(24'h800000)) >> 24);
      sum      = {p_hi_ff[55], p_hi_ff} + $signed({25'd0, low_part});
      // overflow when the 48-bit sign bit and the bits above it are not all equal
      if ((&sum[56:VAL_W-1]) || !(|sum[56:VAL_W-1])) begin
         sat_in    = 1'b0;
         scaled_in = sum[VAL_W-1:0];
      end else begin
         sat_in    = 1'b1;
         scaled_in = sum[56] ? VAL_MIN : VAL_MAX;
      end
   end

   always_ff @(posedge clock) begin
      p_hi_ff   <= p_hi_in;
      p_lo_ff   <= p_lo_in;
      scaled_ff <= scaled_in;
      sat_ff    <= sat_in;
   end

   assign scaled = scaled_ff;
   assign sat    = sat_ff;

endmodule

@@ test/tb_graph_random_projection_embedding_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_random_projection_embedding_unit
// Streams load, edge, run, read and clear commands into the embedding unit
// under several register settings and random back-pressure on both sides.
// A local embedding calculator predicts each response, and the monitor
// compares every field of each response against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_graph_random_projection_embedding_unit;
   import rpe_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int TARGET_CMDS = 1650;

   typedef struct {
      logic [2:0]  op;
      logic [9:0]  node;
      logic [2:0]  dim;
      logic [31:0] pv;
      logic [9:0]  src;
      logic [9:0]  dst;
   } cmd_t;

   typedef struct {
      logic signed [47:0] value;
      logic [1:0]         status;
      logic               sat;
   } answer_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   graph_random_projection_embedding_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // embedding calculator state
   logic [9:0]         edge_a [MAX_EDGES];
   logic [9:0]         edge_b [MAX_EDGES];
   int                 edges_held;
   logic signed [47:0] work_vec [MAX_NODES*MAX_DIMS];
   logic signed [47:0] next_vec [MAX_NODES*MAX_DIMS];
   logic signed [47:0] embed_vec [MAX_NODES*MAX_DIMS];
   logic               sat_flag;
   int                 nodes_used, dims_used, order_used;
   logic signed [31:0] weight [NUM_COEF];

   cmd_t    cmd_backlog[$];
   answer_t answers_due[$];
   cmd_t    drive_cmd;
   logic    took = 1'b0;
   int      send_gap_pct = 0, rsp_stall_pct = 0;
   int      errors = 0;
   int      cycles = 0;

   // stimulus side bookkeeping
   bit      loaded [MAX_NODES*MAX_DIMS];
   int      cmds_issued = 0;
   int      gen_edges = 0;

   function automatic logic signed [47:0] clamp48(input logic signed [81:0] x);
      if (x > 82'(VAL_MAX)) begin
         sat_flag = 1'b1;
         return VAL_MAX;
      end
      if (x < 82'(VAL_MIN)) begin
         sat_flag = 1'b1;
         return VAL_MIN;
      end
      return x[47:0];
   endfunction

   // round to nearest, ties up: add half an LSB, then floor
   function automatic logic signed [47:0] weigh(input logic signed [31:0] c,
                                                input logic signed [47:0] v);
      logic signed [81:0] p;
      p = 82'(c) * 82'(v) + (82'sd1 <<< 23);
      return clamp48(p >>> 24);
   endfunction

   task automatic accumulate(input logic signed [31:0] c);
      int i;
      if (c <= 0) return;
      for (int n = 0; n < nodes_used; n++)
         for (int j = 0; j < dims_used; j++) begin
            i = n*MAX_DIMS + j;
            embed_vec[i] = clamp48(82'(embed_vec[i]) + 82'(weigh(c, work_vec[i])));
         end
   endtask

   task automatic propagate();
      int s, t, is, it;
      sat_flag = 1'b0;
      for (int i = 0; i < MAX_NODES*MAX_DIMS; i++) embed_vec[i] = '0;
      accumulate(weight[0]);
      for (int k = 1; k <= order_used; k++) begin
         for (int j = 0; j < dims_used; j++) begin
            for (int n = 0; n < nodes_used; n++) next_vec[n*MAX_DIMS + j] = '0;
            for (int e = 0; e < edges_held; e++) begin
               s = edge_a[e];
               t = edge_b[e];
               if (s >= nodes_used || t >= nodes_used) continue;
               is = s*MAX_DIMS + j;
               it = t*MAX_DIMS + j;
               next_vec[is] = clamp48(82'(next_vec[is]) + 82'(work_vec[it]));
               next_vec[it] = clamp48(82'(next_vec[it]) + 82'(work_vec[is]));
            end
            for (int n = 0; n < nodes_used; n++)
               work_vec[n*MAX_DIMS + j] = next_vec[n*MAX_DIMS + j];
         end
         accumulate(weight[k]);
      end
   endtask

   task automatic apply_command(input cmd_t c);
      answer_t a;
      int      idx;
      a.value  = '0;
      a.status = STATUS_OK;
      idx = int'(c.node)*MAX_DIMS + int'(c.dim);
      case (c.op)
         OP_LOAD: begin
            if (c.node >= nodes_used || c.dim >= dims_used) a.status = STATUS_RANGE;
            else work_vec[idx] = {{16{c.pv[31]}}, c.pv};
         end
         OP_EDGE: begin
            if (c.src >= nodes_used || c.dst >= nodes_used) a.status = STATUS_RANGE;
            else if (edges_held >= MAX_EDGES) a.status = STATUS_FULL;
            else begin
               edge_a[edges_held] = c.src;
               edge_b[edges_held] = c.dst;
               edges_held++;
            end
         end
         OP_RUN: propagate();
         OP_READ: begin
            if (c.node >= nodes_used || c.dim >= dims_used) a.status = STATUS_RANGE;
            else a.value = embed_vec[idx];
         end
         OP_CLEAR: edges_held = 0;
         default: ;
      endcase
      a.sat = sat_flag;
      answers_due.push_back(a);
   endtask

   task automatic report(input string what);
      $display("[%0d] mismatch: %s", cycles, what);
      errors++;
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || took) begin
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               drive_cmd = cmd_backlog.pop_front();
               req_tdata  <= {7'b0, drive_cmd.dst, drive_cmd.src, drive_cmd.pv,
                              drive_cmd.dim, drive_cmd.node};
               req_tuser  <= drive_cmd.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      answer_t want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         if (rsp_tvalid && rsp_tready && !reset) begin
            if (answers_due.size() == 0) begin
               report("response with nothing expected");
            end else begin
               want = answers_due.pop_front();
               if ($signed(rsp_tdata[47:0]) !== want.value)
                  report($sformatf("read_value %0d, want %0d",
                                   $signed(rsp_tdata[47:0]), want.value));
               if (rsp_tdata[49:48] !== want.status)
                  report($sformatf("status %0d, want %0d", rsp_tdata[49:48], want.status));
               if (rsp_tdata[50] !== want.sat)
                  report($sformatf("saturated %0d, want %0d", rsp_tdata[50], want.sat));
            end
         end
         took <= req_tvalid && req_tready && !reset;
         if (req_tvalid && req_tready && !reset) apply_command(drive_cmd);
      end
   end

   task automatic csr_write(input reg_type r, input logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (r)
         REG_NODE_COUNT: nodes_used = (v[10:0] > MAX_NODES) ? MAX_NODES : int'(v[10:0]);
         REG_DIM_COUNT:  dims_used  = (v[3:0] > MAX_DIMS) ? MAX_DIMS : int'(v[3:0]);
         REG_ORDER:      order_used = (v[2:0] > MAX_ORDER) ? MAX_ORDER : int'(v[2:0]);
         default:        weight[int'(r) - int'(REG_COEF_0)] = v;
      endcase
   endtask

   task automatic setup(input logic [31:0] n, input logic [31:0] d, input logic [31:0] o,
                        input logic [31:0] c0, input logic [31:0] c1, input logic [31:0] c2,
                        input logic [31:0] c3, input logic [31:0] c4);
      csr_write(REG_NODE_COUNT, n);
      csr_write(REG_DIM_COUNT, d);
      csr_write(REG_ORDER, o);
      csr_write(REG_COEF_0, c0);
      csr_write(REG_COEF_1, c1);
      csr_write(REG_COEF_2, c2);
      csr_write(REG_COEF_3, c3);
      csr_write(REG_COEF_4, c4);
   endtask

   task automatic issue(input logic [2:0] op, input int node, input int dim,
                        input logic [31:0] pv, input int src, input int dst);
      cmd_t c;
      c.op = op; c.node = node; c.dim = dim; c.pv = pv; c.src = src; c.dst = dst;
      if (op == OP_LOAD && node < nodes_used && dim < dims_used)
         loaded[node*MAX_DIMS + dim] = 1'b1;
      if (op == OP_EDGE && src < nodes_used && dst < nodes_used) gen_edges++;
      if (op == OP_CLEAR) gen_edges = 0;
      if (op == OP_RUN)
         for (int i = 0; i < nodes_used; i++)
            for (int j = 0; j < dims_used; j++) loaded[i*MAX_DIMS + j] = 1'b1;
      cmd_backlog.push_back(c);
      cmds_issued++;
   endtask

   // hold the sender until every response is back
   task automatic settle();
      while (cmd_backlog.size() > 0 || req_tvalid || answers_due.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($signed($urandom)) >>> 8;
         default: return $urandom_range(1, 32'h0400_0000);
      endcase
   endfunction

   task automatic set_idle(input int mode);
      case (mode)
         0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_gap_pct = 65; rsp_stall_pct = 0;  end
         2: begin send_gap_pct = 0;  rsp_stall_pct = 65; end
         default: begin send_gap_pct = 21; rsp_stall_pct = 21; end
      endcase
   endtask

   initial begin
      int n, d, phase, reads;
      logic [2:0] op;
      edges_held = 0;
      sat_flag   = 1'b0;
      nodes_used = MAX_NODES;
      dims_used  = MAX_DIMS;
      order_used = 1;
      weight = '{32'h0100_0000, 32'h0100_0000, 0, 0, 0};
      for (int i = 0; i < MAX_NODES*MAX_DIMS; i++) begin
         work_vec[i] = '0; next_vec[i] = '0; embed_vec[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a small graph with extreme values, self-loop and range errors
      setup(4, 2, 2, 32'h0100_0000, 32'h7FFF_FFFF, 32'h0080_0000, 32'hFF00_0000, 0);
      issue(OP_LOAD, 0, 0, 32'h7FFF_FFFF, 0, 0);
      issue(OP_LOAD, 0, 1, 32'h8000_0000, 0, 0);
      issue(OP_LOAD, 1, 0, 32'h7FFF_FFFF, 0, 0);
      issue(OP_LOAD, 1, 1, 32'h8000_0000, 0, 0);
      issue(OP_LOAD, 2, 0, 32'h0, 0, 0);
      issue(OP_LOAD, 2, 1, 32'h0000_0001, 0, 0);
      issue(OP_LOAD, 3, 0, 32'hFFFF_FFFF, 0, 0);
      issue(OP_LOAD, 3, 1, 32'h0100_0000, 0, 0);
      issue(OP_LOAD, 4, 0, 32'h1234_5678, 0, 0);
      issue(OP_LOAD, 1023, 7, 32'h1, 0, 0);
      issue(OP_EDGE, 0, 0, 0, 0, 1);
      issue(OP_EDGE, 0, 0, 0, 1, 2);
      issue(OP_EDGE, 0, 0, 0, 3, 3);
      issue(OP_EDGE, 0, 0, 0, 0, 3);
      issue(OP_EDGE, 0, 0, 0, 4, 0);
      issue(OP_EDGE, 0, 0, 0, 0, 1023);
      issue(OP_SPARE_LO, 5, 1, 32'hFFFF_FFFF, 1023, 1023);
      issue(OP_SPARE_HI, 0, 0, 0, 0, 0);
      issue(OP_RUN, 0, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0, 0);
      issue(OP_READ, 3, 1, 0, 0, 0);
      issue(OP_READ, 0, 2, 0, 0, 0);
      issue(OP_CLEAR, 0, 0, 0, 0, 0);
      issue(OP_RUN, 0, 0, 0, 0, 0);
      issue(OP_READ, 1, 1, 0, 0, 0);
      settle();

      // widest setting, fields over their limits; no run here
      setup(32'h7FF, 32'hF, 32'h7, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF);
      issue(OP_LOAD, 1023, 7, 32'h8000_0000, 0, 0);
      issue(OP_EDGE, 0, 0, 0, 1023, 1023);
      issue(OP_READ, 1023, 7, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0, 0);
      settle();

      // fill the edge store, then one more
      set_idle(1);
      setup(2, 1, 1, 0, 32'h0100_0000, 0, 0, 0);
      issue(OP_CLEAR, 0, 0, 0, 0, 0);
      issue(OP_LOAD, 0, 0, 32'h0100_0000, 0, 0);
      issue(OP_LOAD, 1, 0, 32'h0200_0000, 0, 0);
      for (int e = 0; e < MAX_EDGES; e++) issue(OP_EDGE, 0, 0, 0, $urandom_range(1), 1);
      issue(OP_EDGE, 0, 0, 0, 0, 0);
      issue(OP_RUN, 0, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0, 0);
      issue(OP_READ, 1, 0, 0, 0, 0);
      issue(OP_CLEAR, 0, 0, 0, 0, 0);
      settle();
      cmds_issued = 0;

      phase = 0;
      while (cmds_issued < TARGET_CMDS) begin
         set_idle(phase % 4);
         n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
         d = ($urandom_range(5) == 0) ? MAX_DIMS : $urandom_range(1, MAX_DIMS);
         setup(n, d, $urandom_range(0, 4), pick_coef(), pick_coef(), pick_coef(),
               pick_coef(), pick_coef());
         if (gen_edges > 200 || $urandom_range(9) < 7) issue(OP_CLEAR, 0, 0, 0, 0, 0);
         repeat ($urandom_range(0, 3*n)) begin
            if ($urandom_range(9) == 0)
               issue(OP_EDGE, 0, 0, 0, $urandom_range(1023), $urandom_range(n, 1023));
            else
               issue(OP_EDGE, 0, 0, 0, $urandom_range(n-1), $urandom_range(n-1));
         end
         for (int i = 0; i < n; i++)
            for (int j = 0; j < d; j++) begin
               if (!loaded[i*MAX_DIMS + j] || $urandom_range(3) == 0)
                  issue(OP_LOAD, i, j, pick_value(), 0, 0);
               if ($urandom_range(9) == 0) begin
                  op = $urandom_range(7);
                  if (op == OP_RUN) op = OP_READ;
                  issue(op, $urandom_range(1023), $urandom_range(7), $urandom,
                        $urandom_range(1023), $urandom_range(1023));
               end
            end
         if (phase == 3) settle();
         issue(OP_RUN, 0, 0, 0, 0, 0);
         reads = (n*d < 30) ? n*d : 30;
         repeat (reads) issue(OP_READ, $urandom_range(n-1), $urandom_range(d-1), 0, 0, 0);
         issue(OP_READ, $urandom_range(n, 1023), $urandom_range(7), 0, 0, 0);
         if ($urandom_range(9) < 3) begin
            issue(OP_RUN, 0, 0, 0, 0, 0);
            repeat (5) issue(OP_READ, $urandom_range(n-1), $urandom_range(d-1), 0, 0, 0);
         end
         settle();
         phase++;
      end

      settle();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/rpe_pkg.sv
design/rpe_ram.sv
design/rpe_scale.sv
design/graph_random_projection_embedding_unit.sv
test/tb_graph_random_projection_embedding_unit.sv
